@@ hdl/tsri_pkg.sv @@
// ----------------------------------------------------------------------------
// tsri_pkg
// Shared widths, codes and types of the timestamp ring interval search.
// ----------------------------------------------------------------------------
package tsri_pkg;

  localparam int TIME_W = 64;
  localparam int KIND_W = 2;
  localparam int OFS_W  = 10;
  localparam int CNT_W  = 11;
  localparam int MODE_W = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 1'b0,
    MODE_QUERY  = 1'b1
  } tsri_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_SRCH,
    S_FIX,
    S_ADJ,
    S_DONE
  } tsri_state_t;

  // token flags handed from cell to cell
  typedef struct packed {
    logic valid;
    logic pend_a;
    logic pend_b;
  } tsri_flags_t;

endpackage

@@ hdl/tsri_in_if.sv @@
// ----------------------------------------------------------------------------
// tsri_in_if
// Input word channel: append or query command with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsri_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsri_pkg::MODE_W-1:0]   mode;
  logic [tsri_pkg::TIME_W-1:0]   point_time;
  logic [tsri_pkg::KIND_W-1:0]   sample_type;
  logic [tsri_pkg::TIME_W-1:0]   left_time;
  logic [tsri_pkg::TIME_W-1:0]   right_time;
  logic                          include_outer;

  modport source (
    output valid, mode, point_time, sample_type, left_time, right_time, include_outer,
    input  ready
  );

  modport sink (
    input  valid, mode, point_time, sample_type, left_time, right_time, include_outer,
    output ready
  );
endinterface

@@ hdl/tsri_out_if.sv @@
// ----------------------------------------------------------------------------
// tsri_out_if
// Result word channel: append status, query range and entry count.
// ----------------------------------------------------------------------------
interface tsri_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic                        range_valid;
  logic [tsri_pkg::OFS_W-1:0]  first_offset;
  logic [tsri_pkg::OFS_W-1:0]  last_offset;
  logic [tsri_pkg::CNT_W-1:0]  entry_count;

  modport source (
    output valid, accepted, range_valid, first_offset, last_offset, entry_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, range_valid, first_offset, last_offset, entry_count,
    output ready
  );
endinterface

@@ hdl/tsri_ram.sv @@
// ----------------------------------------------------------------------------
// tsri_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tsri_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hdl/tsri_cell.sv @@
// ----------------------------------------------------------------------------
// tsri_cell
// One bisection step for both boundary searches; takes the probe word of
// the previous cell, narrows the bounds and issues the next probe.
// ----------------------------------------------------------------------------
module tsri_cell #(
  parameter int CW = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsri_pkg::tsri_flags_t         flg_i,
  input  logic [CW-1:0]                 lo_a_i,
  input  logic [CW-1:0]                 hi_a_i,
  input  logic [CW-1:0]                 mid_a_i,
  input  logic [CW-1:0]                 lo_b_i,
  input  logic [CW-1:0]                 hi_b_i,
  input  logic [CW-1:0]                 mid_b_i,
  input  logic [tsri_pkg::TIME_W-1:0]   key_a,
  input  logic [tsri_pkg::TIME_W-1:0]   key_b,
  input  logic [tsri_pkg::TIME_W-1:0]   rd_a,
  input  logic [tsri_pkg::TIME_W-1:0]   rd_b,
  output tsri_pkg::tsri_flags_t         flg_o,
  output logic [CW-1:0]                 lo_a_o,
  output logic [CW-1:0]                 hi_a_o,
  output logic [CW-1:0]                 mid_a_o,
  output logic [CW-1:0]                 lo_b_o,
  output logic [CW-1:0]                 hi_b_o,
  output logic [CW-1:0]                 mid_b_o
);

  tsri_pkg::tsri_flags_t flg_r;
  logic [CW-1:0] lo_a_r, hi_a_r, mid_a_r;
  logic [CW-1:0] lo_b_r, hi_b_r, mid_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_r <= '0;
    end else begin
      flg_r <= flg_i;
    end
  end

  always_ff @(posedge clk) begin
    lo_a_r  <= lo_a_i;
    hi_a_r  <= hi_a_i;
    mid_a_r <= mid_a_i;
    lo_b_r  <= lo_b_i;
    hi_b_r  <= hi_b_i;
    mid_b_r <= mid_b_i;
  end

  // first entry at or above key_a
  always_comb begin
    lo_a_o = lo_a_r;
    hi_a_o = hi_a_r;
    if (flg_r.pend_a) begin
      if (rd_a >= key_a) begin
        hi_a_o = mid_a_r;
      end else begin
        lo_a_o = mid_a_r + CW'(1);
      end
    end
    mid_a_o = lo_a_o + ((hi_a_o - lo_a_o) >> 1);
  end

  // first entry above key_b
  always_comb begin
    lo_b_o = lo_b_r;
    hi_b_o = hi_b_r;
    if (flg_r.pend_b) begin
      if (rd_b > key_b) begin
        hi_b_o = mid_b_r;
      end else begin
        lo_b_o = mid_b_r + CW'(1);
      end
    end
    mid_b_o = lo_b_o + ((hi_b_o - lo_b_o) >> 1);
  end

  always_comb begin
    flg_o.valid  = flg_r.valid;
    flg_o.pend_a = flg_r.valid && (lo_a_o < hi_a_o);
    flg_o.pend_b = flg_r.valid && (lo_b_o < hi_b_o);
  end

endmodule

@@ hdl/timestamp_ring_interval_search_core.sv @@
// ----------------------------------------------------------------------------
// timestamp_ring_interval_search_core
// Ring of increasing timestamps with append and interval boundary search.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_if     in   valid/ready        mode, point_time, sample_type,
//                                    left_time, right_time, include_outer
//  out_if    out  valid/ready        accepted, range_valid, first_offset,
//                                    last_offset, entry_count
//  cfg_*     in   cfg_wr_en          cfg_wr_data (capacity_limit)
//
//  append: accept, then result load.
//  query: check, search in the cell chain, fix, adjust, then result load,
//  with one probe per cell per cycle on the two ram read ports.
//  one word in flight; a new word is taken while a result waits on out_if.
//  reset clears state, pointers, count, kind, capacity, out valid; ram is
//  undefined until written, never read before that: no clearing pass.
// ----------------------------------------------------------------------------
module timestamp_ring_interval_search_core #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [tsri_pkg::CNT_W-1:0]  cfg_wr_data,
  tsri_in_if.sink                     in_if,
  tsri_out_if.source                  out_if
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int NCELL = CW + 1;
  localparam int LW    = (CW > tsri_pkg::CNT_W) ? CW : tsri_pkg::CNT_W;
  localparam int SW    = CW + 1;

  tsri_pkg::tsri_state_t state_r, state_nxt;

  logic [tsri_pkg::CNT_W-1:0]  cap_r;
  logic [AW-1:0]               oldest_r, oldest_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [tsri_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [tsri_pkg::TIME_W-1:0] newest_r, newest_nxt;
  logic [tsri_pkg::TIME_W-1:0] lt_r, lt_nxt, rt_r, rt_nxt;
  logic                        outer_r, outer_nxt;
  logic [CW-1:0]               a_r, a_nxt, b_r, b_nxt;

  logic                        res_acc_r, res_acc_nxt;
  logic                        res_rv_r, res_rv_nxt;
  logic [tsri_pkg::OFS_W-1:0]  res_first_r, res_first_nxt;
  logic [tsri_pkg::OFS_W-1:0]  res_last_r, res_last_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_acc_r, out_acc_nxt;
  logic                        out_rv_r, out_rv_nxt;
  logic [tsri_pkg::OFS_W-1:0]  out_first_r, out_first_nxt;
  logic [tsri_pkg::OFS_W-1:0]  out_last_r, out_last_nxt;
  logic [tsri_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic                        in_acc;
  logic                        launch;

  // append path
  logic [LW-1:0]               eff_limit;
  logic                        ap_time_ok, ap_drop, ap_store;
  logic [CW-1:0]               ap_cnt_d;
  logic [AW-1:0]               ap_old_d;

  // ram
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [CW-1:0]               la_a, la_b;
  logic [AW-1:0]               ra_a, ra_b;
  logic [tsri_pkg::TIME_W-1:0] rd_a, rd_b;

  // cell chain
  tsri_pkg::tsri_flags_t       flg_w   [NCELL+1];
  logic [CW-1:0]               lo_a_w  [NCELL+1];
  logic [CW-1:0]               hi_a_w  [NCELL+1];
  logic [CW-1:0]               mid_a_w [NCELL+1];
  logic [CW-1:0]               lo_b_w  [NCELL+1];
  logic [CW-1:0]               hi_b_w  [NCELL+1];
  logic [CW-1:0]               mid_b_w [NCELL+1];
  logic [NCELL-1:0]            cell_vld;
  logic [CW-1:0]               mid_or_a, mid_or_b;

  // boundary widening
  logic [CW-1:0]               adj_a, adj_b;
  logic [LW-1:0]               adj_a_ext, adj_b_ext, cnt_ext;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_acc      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == tsri_pkg::S_IDLE);

  assign out_if.valid        = out_valid_r;
  assign out_if.accepted     = out_acc_r;
  assign out_if.range_valid  = out_rv_r;
  assign out_if.first_offset = out_first_r;
  assign out_if.last_offset  = out_last_r;
  assign out_if.entry_count  = out_cnt_r;

  // append decision
  always_comb begin
    if ((LW'(cap_r) == '0) || (LW'(cap_r) > LW'(DEPTH))) begin
      eff_limit = LW'(DEPTH);
    end else begin
      eff_limit = LW'(cap_r);
    end
    ap_time_ok = (cnt_r == '0) || (in_if.point_time > newest_r);
    ap_drop    = (LW'(cnt_r) >= eff_limit);
    ap_cnt_d   = ap_drop ? (cnt_r - CW'(1)) : cnt_r;
    ap_old_d   = ap_drop ? phys(oldest_r, CW'(1)) : oldest_r;
    ap_store   = ap_time_ok && ((ap_cnt_d == '0) || (in_if.sample_type == kind_r));
    ram_waddr  = phys(ap_old_d, ap_cnt_d);
  end

  // cell chain
  assign flg_w[0]   = '{valid: launch, pend_a: 1'b0, pend_b: 1'b0};
  assign lo_a_w[0]  = '0;
  assign hi_a_w[0]  = cnt_r;
  assign mid_a_w[0] = '0;
  assign lo_b_w[0]  = '0;
  assign hi_b_w[0]  = cnt_r;
  assign mid_b_w[0] = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    tsri_cell #(
      .CW (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .flg_i   (flg_w[k]),
      .lo_a_i  (lo_a_w[k]),
      .hi_a_i  (hi_a_w[k]),
      .mid_a_i (mid_a_w[k]),
      .lo_b_i  (lo_b_w[k]),
      .hi_b_i  (hi_b_w[k]),
      .mid_b_i (mid_b_w[k]),
      .key_a   (lt_r),
      .key_b   (rt_r),
      .rd_a    (rd_a),
      .rd_b    (rd_b),
      .flg_o   (flg_w[k+1]),
      .lo_a_o  (lo_a_w[k+1]),
      .hi_a_o  (hi_a_w[k+1]),
      .mid_a_o (mid_a_w[k+1]),
      .lo_b_o  (lo_b_w[k+1]),
      .hi_b_o  (hi_b_w[k+1]),
      .mid_b_o (mid_b_w[k+1])
    );
    assign cell_vld[k] = flg_w[k+1].valid;
  end

  always_comb begin
    mid_or_a = '0;
    mid_or_b = '0;
    for (int k = 0; k < NCELL; k++) begin
      if (cell_vld[k]) begin
        mid_or_a = mid_or_a | mid_a_w[k+1];
        mid_or_b = mid_or_b | mid_b_w[k+1];
      end
    end
  end

  // read address select, offsets are from the oldest entry
  always_comb begin
    unique case (state_r)
      tsri_pkg::S_SRCH: begin
        la_a = mid_or_a;
        la_b = mid_or_b;
      end
      tsri_pkg::S_FIX: begin
        la_a = a_r;
        la_b = b_r;
      end
      default: begin
        la_a = '0;
        la_b = '0;
      end
    endcase
    ra_a = phys(oldest_r, la_a);
    ra_b = phys(oldest_r, la_b);
  end

  tsri_ram #(
    .WIDTH (tsri_pkg::TIME_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_if.point_time),
    .raddr_a (ra_a),
    .rdata_a (rd_a),
    .raddr_b (ra_b),
    .rdata_b (rd_b)
  );

  // outer widening by one neighbor
  always_comb begin
    adj_a = a_r;
    adj_b = b_r;
    if (outer_r) begin
      if ((rd_a != lt_r) && (a_r != '0)) begin
        adj_a = a_r - CW'(1);
      end
      if ((rd_b != rt_r) && ((b_r + CW'(1)) < cnt_r)) begin
        adj_b = b_r + CW'(1);
      end
    end
  end

  assign adj_a_ext = LW'(adj_a);
  assign adj_b_ext = LW'(adj_b);
  assign cnt_ext   = LW'(cnt_r);

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    newest_nxt    = newest_r;
    lt_nxt        = lt_r;
    rt_nxt        = rt_r;
    outer_nxt     = outer_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_acc_nxt   = res_acc_r;
    res_rv_nxt    = res_rv_r;
    res_first_nxt = res_first_r;
    res_last_nxt  = res_last_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_acc_nxt   = out_acc_r;
    out_rv_nxt    = out_rv_r;
    out_first_nxt = out_first_r;
    out_last_nxt  = out_last_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    launch        = 1'b0;

    unique case (state_r)
      tsri_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_if.mode == tsri_pkg::MODE_APPEND) begin
            if (ap_time_ok) begin
              oldest_nxt = ap_old_d;
              cnt_nxt    = ap_cnt_d;
              if (ap_store) begin
                cnt_nxt    = ap_cnt_d + CW'(1);
                newest_nxt = in_if.point_time;
                ram_we     = 1'b1;
                if (ap_cnt_d == '0) begin
                  kind_nxt = in_if.sample_type;
                end
              end
            end
            res_acc_nxt   = ap_store;
            res_rv_nxt    = 1'b0;
            res_first_nxt = '0;
            res_last_nxt  = '0;
            state_nxt     = tsri_pkg::S_DONE;
          end else begin
            lt_nxt    = in_if.left_time;
            rt_nxt    = in_if.right_time;
            outer_nxt = in_if.include_outer;
            state_nxt = tsri_pkg::S_CHK;
          end
        end
      end
      tsri_pkg::S_CHK: begin
        // rd_a holds the oldest entry here
        if ((cnt_r > CW'(1)) && (lt_r < rt_r) && (lt_r <= newest_r) && (rt_r > rd_a)) begin
          launch    = 1'b1;
          state_nxt = tsri_pkg::S_SRCH;
        end else begin
          res_acc_nxt   = 1'b0;
          res_rv_nxt    = 1'b0;
          res_first_nxt = '0;
          res_last_nxt  = '0;
          state_nxt     = tsri_pkg::S_DONE;
        end
      end
      tsri_pkg::S_SRCH: begin
        if (flg_w[NCELL].valid) begin
          a_nxt     = lo_a_w[NCELL];
          b_nxt     = lo_b_w[NCELL] - CW'(1);
          state_nxt = tsri_pkg::S_FIX;
        end
      end
      tsri_pkg::S_FIX: begin
        state_nxt = tsri_pkg::S_ADJ;
      end
      tsri_pkg::S_ADJ: begin
        res_acc_nxt = 1'b0;
        if (adj_b > adj_a) begin
          res_rv_nxt    = 1'b1;
          res_first_nxt = adj_a_ext[tsri_pkg::OFS_W-1:0];
          res_last_nxt  = adj_b_ext[tsri_pkg::OFS_W-1:0];
        end else begin
          res_rv_nxt    = 1'b0;
          res_first_nxt = '0;
          res_last_nxt  = '0;
        end
        state_nxt = tsri_pkg::S_DONE;
      end
      tsri_pkg::S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = res_acc_r;
          out_rv_nxt    = res_rv_r;
          out_first_nxt = res_first_r;
          out_last_nxt  = res_last_r;
          out_cnt_nxt   = cnt_ext[tsri_pkg::CNT_W-1:0];
          state_nxt     = tsri_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tsri_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsri_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= '0;
      oldest_r    <= '0;
      cnt_r       <= '0;
      kind_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      oldest_r    <= oldest_nxt;
      cnt_r       <= cnt_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newest_r    <= newest_nxt;
    lt_r        <= lt_nxt;
    rt_r        <= rt_nxt;
    outer_r     <= outer_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    res_acc_r   <= res_acc_nxt;
    res_rv_r    <= res_rv_nxt;
    res_first_r <= res_first_nxt;
    res_last_r  <= res_last_nxt;
    out_acc_r   <= out_acc_nxt;
    out_rv_r    <= out_rv_nxt;
    out_first_r <= out_first_nxt;
    out_last_r  <= out_last_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_vld))
    else $error("more than one search token in the cell chain");

  a_query_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_acc && (in_if.mode == tsri_pkg::MODE_QUERY)) |=> (cnt_r == $past(cnt_r)))
    else $error("query word changed the entry count");

  a_append_step: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_acc && (in_if.mode == tsri_pkg::MODE_APPEND)) |=>
      ((cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CW'(1)) ||
       (cnt_r + CW'(1) == $past(cnt_r))))
    else $error("append word moved the entry count by more than one");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == tsri_pkg::S_DONE))
    else $error("result word raised outside the done state");

endmodule

@@ dv/timestamp_ring_interval_search_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timestamp_ring_interval_search_core_tb
// Drives append and query words into the timestamp ring, keeps its own copy
// of the ring and the capacity register, and checks every result word field
// by field in order, under varying sender gaps, receiver stalls and limits.
// ----------------------------------------------------------------------------
module timestamp_ring_interval_search_core_tb;

  localparam int DEPTH         = 1024;
  localparam int RING_AW       = $clog2(DEPTH);
  localparam int PRESSURE_HOLD = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam logic [tsri_pkg::TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    tsri_pkg::tsri_mode_t                mode;
    logic [tsri_pkg::TIME_W-1:0]         point_time;
    logic [tsri_pkg::KIND_W-1:0]         sample_type;
    logic [tsri_pkg::TIME_W-1:0]         left_time;
    logic [tsri_pkg::TIME_W-1:0]         right_time;
    logic                                include_outer;
  } cmd_t;

  typedef struct packed {
    logic                                accepted;
    logic                                range_valid;
    logic [tsri_pkg::OFS_W-1:0]          first_offset;
    logic [tsri_pkg::OFS_W-1:0]          last_offset;
    logic [tsri_pkg::CNT_W-1:0]          entry_count;
  } status_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [tsri_pkg::CNT_W-1:0] cfg_wr_data;

  tsri_in_if  in_ch ();
  tsri_out_if out_ch ();

  timestamp_ring_interval_search_core #(.DEPTH(DEPTH)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always #1 clk = ~clk;

  // ring copy and capacity register
  logic [tsri_pkg::TIME_W-1:0] ring_time [DEPTH];
  int unsigned                 ring_head;
  int unsigned                 ring_count;
  int unsigned                 ring_cap_reg;
  logic [tsri_pkg::KIND_W-1:0] ring_kind;

  status_t     due_status [$];
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned words_sent;
  int unsigned appends_stored;
  int unsigned ranges_found;
  int unsigned peak_count;
  int unsigned cap_writes;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  logic        hold_kick;

  function automatic logic [tsri_pkg::TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [tsri_pkg::TIME_W-1:0] ring_at(int unsigned k);
    return ring_time[RING_AW'((ring_head + k) % DEPTH)];
  endfunction

  function automatic logic [tsri_pkg::TIME_W-1:0] newest_time();
    return (ring_count != 0) ? ring_at(ring_count - 1) : '0;
  endfunction

  function automatic int unsigned ring_cap();
    if (ring_cap_reg == 0 || ring_cap_reg > DEPTH) return DEPTH;
    return ring_cap_reg;
  endfunction

  // first offset at or above x, or strictly above x
  function automatic int unsigned ring_bound(logic [tsri_pkg::TIME_W-1:0] x, bit strict);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = ring_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (strict ? (ring_at(mid) > x) : (ring_at(mid) >= x)) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  task automatic ring_update(input cmd_t c, output status_t s);
    int unsigned a;
    int unsigned b;
    s = '0;
    if (c.mode == tsri_pkg::MODE_APPEND) begin
      if (ring_count == 0 || c.point_time > newest_time()) begin
        if (ring_count >= ring_cap()) begin
          ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
        end
        if (ring_count == 0 || c.sample_type == ring_kind) begin
          if (ring_count == 0) ring_kind = c.sample_type;
          ring_time[RING_AW'((ring_head + ring_count) % DEPTH)] = c.point_time;
          ring_count++;
          s.accepted = 1'b1;
          appends_stored++;
          if (ring_count > peak_count) peak_count = ring_count;
        end
      end
    end else if (ring_count > 1 && c.left_time < c.right_time &&
                 c.left_time <= newest_time() && c.right_time > ring_at(0)) begin
      a = ring_bound(c.left_time, 1'b0);
      b = ring_bound(c.right_time, 1'b1) - 1;
      if (c.include_outer) begin
        if (ring_at(a) != c.left_time && a > 0) a--;
        if (ring_at(b) != c.right_time && b + 1 < ring_count) b++;
      end
      if (b > a) begin
        s.range_valid  = 1'b1;
        s.first_offset = tsri_pkg::OFS_W'(a);
        s.last_offset  = tsri_pkg::OFS_W'(b);
        ranges_found++;
      end
    end
    s.entry_count = tsri_pkg::CNT_W'(ring_count);
  endtask

  function automatic cmd_t append_cmd(logic [tsri_pkg::TIME_W-1:0] t,
                                      logic [tsri_pkg::KIND_W-1:0] k);
    cmd_t c;
    c.mode          = tsri_pkg::MODE_APPEND;
    c.point_time    = t;
    c.sample_type   = k;
    c.left_time     = rand64();
    c.right_time    = rand64();
    c.include_outer = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic cmd_t query_cmd(logic [tsri_pkg::TIME_W-1:0] lt,
                                     logic [tsri_pkg::TIME_W-1:0] rt,
                                     logic outer);
    cmd_t c;
    c.mode          = tsri_pkg::MODE_QUERY;
    c.point_time    = rand64();
    c.sample_type   = tsri_pkg::KIND_W'($urandom_range(3));
    c.left_time     = lt;
    c.right_time    = rt;
    c.include_outer = outer;
    return c;
  endfunction

  // mostly in-order times with the latched kind, some stale or foreign words
  function automatic cmd_t random_append();
    logic [tsri_pkg::TIME_W-1:0] t;
    logic [tsri_pkg::KIND_W-1:0] k;
    int unsigned                 r;
    r = $urandom_range(99);
    t = newest_time();
    k = (ring_count != 0 && $urandom_range(99) < 94) ? ring_kind
                                                     : tsri_pkg::KIND_W'($urandom_range(3));
    if (r < 60) t = t + tsri_pkg::TIME_W'($urandom_range(16, 1));
    else if (r < 85) t = t + tsri_pkg::TIME_W'($urandom_range(100000, 1));
    else if (r < 94 || ring_count == 0) t = t + tsri_pkg::TIME_W'($urandom) + 1;
    else if (r < 97) t = t - tsri_pkg::TIME_W'($urandom_range(3));
    else begin
      t = rand64();
      if (t > newest_time()) k = ring_kind ^ 2'd1;
    end
    return append_cmd(t, k);
  endfunction

  function automatic logic [tsri_pkg::TIME_W-1:0] probe_time();
    int unsigned r;
    r = $urandom_range(99);
    if (ring_count == 0 || r >= 90) return rand64();
    if (r < 45) return ring_at($urandom_range(ring_count - 1));
    if (r < 75)
      return ring_at($urandom_range(ring_count - 1)) +
             tsri_pkg::TIME_W'($urandom_range(2)) - 1;
    if (r < 82) return ring_at(0) - tsri_pkg::TIME_W'($urandom_range(5));
    return newest_time() + tsri_pkg::TIME_W'($urandom_range(5));
  endfunction

  function automatic cmd_t random_query();
    logic [tsri_pkg::TIME_W-1:0] p;
    logic [tsri_pkg::TIME_W-1:0] q;
    logic [tsri_pkg::TIME_W-1:0] tmp;
    p = probe_time();
    q = probe_time();
    if (p > q && $urandom_range(99) < 85) begin
      tmp = p;
      p   = q;
      q   = tmp;
    end
    return query_cmd(p, q, 1'($urandom_range(1)));
  endfunction

  function automatic cmd_t random_item(int unsigned append_pct);
    return ($urandom_range(99) < append_pct) ? random_append() : random_query();
  endfunction

  task automatic report_mismatch(string what, logic [tsri_pkg::TIME_W-1:0] got,
                                 logic [tsri_pkg::TIME_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("mismatch at result word %0d: %s got %0h want %0h",
               results_seen, what, got, want);
  endtask

  task automatic send_word(input cmd_t c);
    status_t st;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= c.mode;
    in_ch.point_time    <= c.point_time;
    in_ch.sample_type   <= c.sample_type;
    in_ch.left_time     <= c.left_time;
    in_ch.right_time    <= c.right_time;
    in_ch.include_outer <= c.include_outer;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    ring_update(c, st);
    due_status.push_back(st);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (due_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(int unsigned v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tsri_pkg::CNT_W'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ring_cap_reg = v;
    cap_writes++;
  endtask

  task automatic set_idling(int unsigned gap, int unsigned stall);
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  task automatic test_kind_latch();
    set_idling(0, 0);
    send_word(query_cmd(64'd0, TIME_MAX, 1'b1));
    send_word(append_cmd(64'd0, 2'd3));
    send_word(append_cmd(64'd0, 2'd3));
    send_word(append_cmd(64'd10, 2'd0));
    send_word(append_cmd(64'd10, 2'd3));
    send_word(append_cmd(64'd20, 2'd3));
    send_word(append_cmd(64'd30, 2'd3));
  endtask

  task automatic test_interval_search();
    send_word(query_cmd(64'd10, 64'd20, 1'b0));
    send_word(query_cmd(64'd10, 64'd20, 1'b1));
    send_word(query_cmd(64'd5, 64'd25, 1'b0));
    send_word(query_cmd(64'd5, 64'd25, 1'b1));
    send_word(query_cmd(64'd0, TIME_MAX, 1'b1));
    send_word(query_cmd(64'd20, 64'd20, 1'b0));
    send_word(query_cmd(64'd31, 64'd40, 1'b1));
    send_word(query_cmd(64'd11, 64'd19, 1'b0));
    send_word(query_cmd(64'd11, 64'd19, 1'b1));
  endtask

  task automatic test_capacity_limit();
    write_capacity(4);
    send_word(append_cmd(64'd40, 2'd0));
    send_word(append_cmd(64'd50, 2'd3));
    send_word(query_cmd(64'd0, 64'd10, 1'b1));
    write_capacity(2);
    send_word(append_cmd(64'd60, 2'd3));
    send_word(append_cmd(64'd70, 2'd3));
    write_capacity(1);
    send_word(append_cmd(64'd80, 2'd0));
    write_capacity(2047);
    send_word(append_cmd(64'd90, 2'd3));
  endtask

  task automatic test_random_stream();
    logic [3:0]  prefixes [4] = '{4'h0, 4'h1, 4'h6, 4'h9};
    int unsigned gaps     [4] = '{0, 47, 0, 28};
    int unsigned stalls   [4] = '{0, 0, 47, 28};
    int unsigned caps     [4];
    caps = '{$urandom_range(12, 5), 2, $urandom_range(64, 16), 0};
    for (int ph = 0; ph < 4; ph++) begin
      write_capacity(caps[ph]);
      set_idling(gaps[ph], stalls[ph]);
      // jump the time base so the upper bits move
      if (prefixes[ph] != 4'h0)
        send_word(append_cmd({prefixes[ph], 60'(rand64())}, ring_kind));
      repeat (200) send_word(random_item(70));
    end
  endtask

  task automatic test_full_ring();
    set_idling(0, 0);
    write_capacity(2047);
    send_word(append_cmd({4'hC, 60'(rand64())}, ring_kind));
    while (ring_count < DEPTH) send_word(random_item(97));
    set_idling(28, 28);
    repeat (40) send_word(random_item(50));
    write_capacity(DEPTH);
    set_idling(0, 47);
    repeat (30) send_word(random_item(60));
    write_capacity(0);
    set_idling(47, 0);
    repeat (30) send_word(random_item(60));
  endtask

  task automatic test_back_pressure();
    set_idling(0, 0);
    wait_idle();
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    repeat (24) send_word(random_item(50));
  endtask

  task automatic test_time_ceiling();
    set_idling(28, 28);
    send_word(append_cmd(TIME_MAX - 1, ring_kind));
    send_word(append_cmd(TIME_MAX, ring_kind));
    send_word(append_cmd(TIME_MAX, ring_kind));
    send_word(query_cmd(TIME_MAX - 1, TIME_MAX, 1'b0));
    send_word(query_cmd(TIME_MAX, TIME_MAX, 1'b1));
    send_word(query_cmd(64'd0, TIME_MAX, 1'b1));
  endtask

  // result side: random stalls plus one long hold on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_kick) begin
      hold_left = PRESSURE_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    status_t due;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (due_status.size() == 0) begin
        report_mismatch("word with nothing due, entry_count",
                        tsri_pkg::TIME_W'(out_ch.entry_count), '0);
      end else begin
        due = due_status.pop_front();
        if (out_ch.accepted !== due.accepted)
          report_mismatch("accepted", tsri_pkg::TIME_W'(out_ch.accepted),
                          tsri_pkg::TIME_W'(due.accepted));
        if (out_ch.range_valid !== due.range_valid)
          report_mismatch("range_valid", tsri_pkg::TIME_W'(out_ch.range_valid),
                          tsri_pkg::TIME_W'(due.range_valid));
        if (out_ch.first_offset !== due.first_offset)
          report_mismatch("first_offset", tsri_pkg::TIME_W'(out_ch.first_offset),
                          tsri_pkg::TIME_W'(due.first_offset));
        if (out_ch.last_offset !== due.last_offset)
          report_mismatch("last_offset", tsri_pkg::TIME_W'(out_ch.last_offset),
                          tsri_pkg::TIME_W'(due.last_offset));
        if (out_ch.entry_count !== due.entry_count)
          report_mismatch("entry_count", tsri_pkg::TIME_W'(out_ch.entry_count),
                          tsri_pkg::TIME_W'(due.entry_count));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timestamp_ring_interval_search_core_tb: errors");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = tsri_pkg::MODE_APPEND;
    in_ch.point_time    = '0;
    in_ch.sample_type   = '0;
    in_ch.left_time     = '0;
    in_ch.right_time    = '0;
    in_ch.include_outer = 1'b0;
    out_ch.ready        = 1'b0;
    hold_kick           = 1'b0;
    hold_left           = 0;
    ring_head           = 0;
    ring_count          = 0;
    ring_cap_reg        = 0;
    ring_kind           = '0;
    mismatch_count      = 0;
    results_seen        = 0;
    words_sent          = 0;
    appends_stored      = 0;
    ranges_found        = 0;
    peak_count          = 0;
    cap_writes          = 0;
    set_idling(0, 0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_kind_latch();
    test_interval_search();
    test_capacity_limit();
    test_random_stream();
    test_full_ring();
    test_back_pressure();
    test_time_ceiling();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_status.size() != 0)
      report_mismatch("results never seen", tsri_pkg::TIME_W'(due_status.size()), '0);
    $display("%0d words sent, %0d results checked, %0d capacity writes",
             words_sent, results_seen, cap_writes);
    $display("%0d points stored, %0d valid ranges, ring peaked at %0d entries",
             appends_stored, ranges_found, peak_count);
    if (mismatch_count == 0) begin
      $display("timestamp_ring_interval_search_core_tb: clean");
    end else begin
      $display("timestamp_ring_interval_search_core_tb: errors");
    end
    $finish;
  end

endmodule
